// ===== rtl/core/rc4_pkg.sv =====
// rc4_pkg: shared constants, control word layout and microcode store for the rc4 engine
// depends on nothing; used by rc4_seq, rc4_stream_cipher_unit and rc4_chk

package rc4_pkg;

  localparam int unsigned KEY_MAX   = 256;
  localparam int unsigned KEY_IDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int unsigned KEY_LEN_W = $clog2(KEY_MAX + 1);

  // input op codes
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_NOKEY = 1'b1;

  typedef logic [3:0] step_t;

  // microprogram step codes
  localparam step_t STEP_IDLE = 4'd0;
  localparam step_t STEP_FILL = 4'd1;
  localparam step_t STEP_K1   = 4'd2;
  localparam step_t STEP_K2   = 4'd3;
  localparam step_t STEP_K3   = 4'd4;
  localparam step_t STEP_K4   = 4'd5;
  localparam step_t STEP_FIN  = 4'd6;
  localparam step_t STEP_P2   = 4'd7;
  localparam step_t STEP_P3   = 4'd8;
  localparam step_t STEP_P4   = 4'd9;
  localparam step_t STEP_P5   = 4'd10;

  typedef enum logic [1:0] {RA_INEXT, RA_N, RA_JSUM, RA_TSUM} ra_sel_e;
  typedef enum logic [1:0] {WA_N, WA_I, WA_J} wa_sel_e;
  typedef enum logic [1:0] {WD_N, WD_RD, WD_SI} wd_sel_e;
  typedef enum logic [1:0] {J_HOLD, J_KSA, J_PRGA} j_op_e;
  typedef enum logic [1:0] {SQ_NEXT, SQ_JUMP, SQ_LOOP, SQ_DISPATCH} seq_e;

  typedef struct packed {
    logic    ready;   // request port open
    ra_sel_e ra;      // permutation read address
    logic    we;      // permutation write
    wa_sel_e wa;
    wd_sel_e wd;
    logic    ld_si;
    logic    ld_sj;
    j_op_e   jop;
    logic    n_inc;
    logic    k_step;
    logic    fin;     // schedule done
    logic    out_ld;  // keystream result
    seq_e    seq;
    step_t   target;
  } ctrl_t;

  // dispatch decision taken in the idle step
  typedef struct packed {
    logic go_sched;
    logic go_prga;
  } disp_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c = '0;
    case (s)
      STEP_IDLE: begin
        c.ready = 1'b1;
        c.ra    = RA_INEXT;
        c.seq   = SQ_DISPATCH;
      end
      STEP_FILL: begin
        c.we     = 1'b1;
        c.wa     = WA_N;
        c.wd     = WD_N;
        c.n_inc  = 1'b1;
        c.seq    = SQ_LOOP;
        c.target = STEP_FILL;
      end
      STEP_K1: begin
        c.ra  = RA_N;
        c.seq = SQ_NEXT;
      end
      STEP_K2: begin
        c.ra    = RA_JSUM;
        c.jop   = J_KSA;
        c.ld_si = 1'b1;
        c.seq   = SQ_NEXT;
      end
      STEP_K3: begin
        c.we  = 1'b1;
        c.wa  = WA_N;
        c.wd  = WD_RD;
        c.seq = SQ_NEXT;
      end
      STEP_K4: begin
        c.we     = 1'b1;
        c.wa     = WA_J;
        c.wd     = WD_SI;
        c.n_inc  = 1'b1;
        c.k_step = 1'b1;
        c.seq    = SQ_LOOP;
        c.target = STEP_K1;
      end
      STEP_FIN: begin
        c.fin    = 1'b1;
        c.seq    = SQ_JUMP;
        c.target = STEP_IDLE;
      end
      STEP_P2: begin
        c.ra    = RA_JSUM;
        c.jop   = J_PRGA;
        c.ld_si = 1'b1;
        c.seq   = SQ_NEXT;
      end
      STEP_P3: begin
        c.we    = 1'b1;
        c.wa    = WA_I;
        c.wd    = WD_RD;
        c.ld_sj = 1'b1;
        c.seq   = SQ_NEXT;
      end
      STEP_P4: begin
        c.we  = 1'b1;
        c.wa  = WA_J;
        c.wd  = WD_SI;
        c.ra  = RA_TSUM;
        c.seq = SQ_NEXT;
      end
      STEP_P5: begin
        c.out_ld = 1'b1;
        c.seq    = SQ_JUMP;
        c.target = STEP_IDLE;
      end
      default: begin
        c.seq    = SQ_JUMP;
        c.target = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/rc4_if.sv =====
// rc4_if: request and result channel interfaces of the rc4 engine
// no dependencies

interface rc4_req_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] value;
  logic       last;

  modport source (output valid, output op, output value, output last, input ready);
  modport sink   (input valid, input op, input value, input last, output ready);
endinterface

interface rc4_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       status;

  modport source (output valid, output out_byte, output status, input ready);
  modport sink   (input valid, input out_byte, input status, output ready);
endinterface

// ===== rtl/core/rc4_stream_cipher_unit.sv =====
// rc4_stream_cipher_unit: rc4 engine top level, permutation and key memories plus datapath
// depends on rc4_pkg, rc4_if (rc4_req_if, rc4_rsp_if) and rc4_seq
//
//   port    | dir | request contents
//   --------+-----+------------------------------------------------
//   req_i   | in  | op (key/data), value byte, last key flag
//   rsp_o   | out | out_byte, status (ok / no key scheduled)
//
// key byte without last: taken in the idle step; data byte: idle + 4 microcode steps,
// bound by the single read port of the permutation memory (S[i], S[j], keystream read)
// last key byte: idle, identity fill of 256 entries, 4 steps per swap, then the fin step
// reset: step counter to idle, no key scheduled, no key load in progress
// a request is taken only in the idle step and only while the result register is free
// or being drained; a held result blocks new requests

module rc4_stream_cipher_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  rc4_req_if.sink          req_i,
  rc4_rsp_if.source        rsp_o
);

  localparam int unsigned KW = rc4_pkg::KEY_IDX_W;
  localparam int unsigned LW = rc4_pkg::KEY_LEN_W;

  rc4_pkg::ctrl_t ctrl;
  rc4_pkg::disp_t disp;

  // control state
  logic          key_ready_q, key_ready_d;
  logic          loading_q, loading_d;
  logic [LW-1:0] len_q, len_d;
  logic [7:0]    i_q, i_d;
  logic [7:0]    j_q, j_d;
  logic [7:0]    n_q, n_d;
  logic [KW-1:0] k_q, k_d;
  logic          out_vld_q, out_vld_d;

  // payload registers
  logic [7:0]    si_q, sj_q, val_q;
  logic [7:0]    out_byte_q;
  logic          status_q;
  logic [7:0]    prd_q;       // permutation read data
  logic [7:0]    krd_q;       // key read data

  // memories
  logic [7:0]    perm_mem [256];
  logic [7:0]    key_mem  [rc4_pkg::KEY_MAX];

  logic          acc, acc_key, acc_data;
  logic [LW-1:0] base_len;
  logic          kwe;
  logic [7:0]    j_sum, t_sum, ra, wa, wd, ks;
  logic [LW-1:0] k_inc;

  // handshake: requests only in the idle step with a free result slot
  assign req_i.ready = ctrl.ready && (!out_vld_q || rsp_o.ready);
  assign acc         = req_i.valid && req_i.ready;
  assign acc_key     = acc && (req_i.op == rc4_pkg::OP_KEY);
  assign acc_data    = acc && (req_i.op == rc4_pkg::OP_DATA);

  assign disp.go_sched = acc_key && req_i.last;
  assign disp.go_prga  = acc_data && key_ready_q;

  rc4_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .disp_i   (disp),
    .n_last_i (n_q == 8'hFF),
    .ctrl_o   (ctrl)
  );

  // key store write: a key byte outside a load starts a new key at entry zero
  assign base_len = loading_q ? len_q : '0;
  assign kwe      = acc_key && (base_len < LW'(rc4_pkg::KEY_MAX));

  // j update: ksa adds S[n] and key[k], prga adds S[i]
  always_comb begin
    case (ctrl.jop)
      rc4_pkg::J_KSA:  j_sum = j_q + prd_q + krd_q;
      rc4_pkg::J_PRGA: j_sum = j_q + prd_q;
      default:         j_sum = j_q;
    endcase
  end

  assign t_sum = si_q + sj_q;

  always_comb begin
    case (ctrl.ra)
      rc4_pkg::RA_INEXT: ra = i_q + 8'd1;
      rc4_pkg::RA_N:     ra = n_q;
      rc4_pkg::RA_JSUM:  ra = j_sum;
      rc4_pkg::RA_TSUM:  ra = t_sum;
      default:           ra = n_q;
    endcase
  end

  always_comb begin
    case (ctrl.wa)
      rc4_pkg::WA_N: wa = n_q;
      rc4_pkg::WA_I: wa = i_q;
      rc4_pkg::WA_J: wa = j_q;
      default:       wa = n_q;
    endcase
  end

  always_comb begin
    case (ctrl.wd)
      rc4_pkg::WD_N:  wd = n_q;
      rc4_pkg::WD_RD: wd = prd_q;
      rc4_pkg::WD_SI: wd = si_q;
      default:        wd = n_q;
    endcase
  end

  // keystream read overlaps the S[j] write; bypass when t hits j
  assign ks = (t_sum == j_q) ? si_q : prd_q;

  // key index wraps at the key length
  assign k_inc = LW'(k_q) + LW'(1);

  always_comb begin
    key_ready_d = key_ready_q;
    loading_d   = loading_q;
    len_d       = len_q;
    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    k_d         = k_q;
    out_vld_d   = out_vld_q;

    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    if (acc_key) begin
      loading_d = 1'b1;
      len_d     = kwe ? base_len + LW'(1) : base_len;
      if (!loading_q) begin
        key_ready_d = 1'b0;
      end
    end

    // error result for data ahead of any scheduled key
    if (acc_data && !key_ready_q) begin
      out_vld_d = 1'b1;
    end

    if (disp.go_sched) begin
      n_d = '0;
      k_d = '0;
      j_d = '0;
    end

    if (disp.go_prga) begin
      i_d = i_q + 8'd1;
    end

    if (ctrl.jop != rc4_pkg::J_HOLD) begin
      j_d = j_sum;
    end

    if (ctrl.n_inc) begin
      n_d = n_q + 8'd1;
    end

    if (ctrl.k_step) begin
      k_d = (k_inc == len_q) ? '0 : k_inc[KW-1:0];
    end

    if (ctrl.fin) begin
      i_d         = '0;
      j_d         = '0;
      key_ready_d = 1'b1;
      loading_d   = 1'b0;
    end

    if (ctrl.out_ld) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_ready_q <= 1'b0;
      loading_q   <= 1'b0;
      len_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      k_q         <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      key_ready_q <= key_ready_d;
      loading_q   <= loading_d;
      len_q       <= len_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      k_q         <= k_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (ctrl.ld_si) begin
      si_q <= prd_q;
    end
    if (ctrl.ld_sj) begin
      sj_q <= prd_q;
    end
    if (disp.go_prga) begin
      val_q <= req_i.value;
    end
    if (acc_data && !key_ready_q) begin
      out_byte_q <= req_i.value;
      status_q   <= rc4_pkg::STATUS_NOKEY;
    end else if (ctrl.out_ld) begin
      out_byte_q <= val_q ^ ks;
      status_q   <= rc4_pkg::STATUS_OK;
    end
  end

  // permutation memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (ctrl.we) begin
      perm_mem[wa] <= wd;
    end
    prd_q <= perm_mem[ra];
  end

  // key memory: written in the idle step, read at the key index
  always_ff @(posedge clk_i) begin
    if (kwe) begin
      key_mem[base_len[KW-1:0]] <= req_i.value;
    end
    krd_q <= key_mem[k_q];
  end

  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.out_byte = out_byte_q;
  assign rsp_o.status   = status_q;

endmodule

// ===== rtl/core/rc4_seq.sv =====
// rc4_seq: step counter and microcode fetch with conditional jumps
// depends on rc4_pkg

module rc4_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rc4_pkg::disp_t disp_i,
  input  logic           n_last_i,
  output rc4_pkg::ctrl_t ctrl_o
);

  rc4_pkg::step_t step_q, step_d;

  assign ctrl_o = rc4_pkg::ucode(step_q);

  always_comb begin
    step_d = step_q;
    case (ctrl_o.seq)
      rc4_pkg::SQ_NEXT: step_d = step_q + rc4_pkg::step_t'(1);
      rc4_pkg::SQ_JUMP: step_d = ctrl_o.target;
      rc4_pkg::SQ_LOOP: step_d = n_last_i ? step_q + rc4_pkg::step_t'(1) : ctrl_o.target;
      rc4_pkg::SQ_DISPATCH: begin
        if (disp_i.go_sched) begin
          step_d = rc4_pkg::STEP_FILL;
        end else if (disp_i.go_prga) begin
          step_d = rc4_pkg::STEP_P2;
        end
      end
      default: step_d = rc4_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= rc4_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== rtl/core/rc4_chk.sv =====
// rc4_chk: port-level checks of the rc4 engine, bound to rc4_stream_cipher_unit
// depends on rc4_pkg and the top level's ports

module rc4_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       req_op_i,
  input logic       req_last_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [7:0] rsp_out_byte_i,
  input logic       rsp_status_i
);

  logic req_acc;
  assign req_acc = req_valid_i && req_ready_i;

  // a held result keeps its value
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_out_byte_i)
      && $stable(rsp_status_i))
    else $error("result changed while stalled");

  // no request taken while a result sits undelivered
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |-> !rsp_valid_i || rsp_ready_i)
    else $error("request accepted over a blocked result");

  // a data byte either starts the keystream step or returns its error at once
  a_data_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && (req_op_i == rc4_pkg::OP_DATA) |=> !req_ready_i || rsp_valid_i)
    else $error("data request neither busy nor answered");

  // the final key byte starts scheduling and gives no result
  a_sched_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && (req_op_i == rc4_pkg::OP_KEY) && req_last_i |=> !req_ready_i && !rsp_valid_i)
    else $error("key schedule did not hold off requests");

endmodule

bind rc4_stream_cipher_unit rc4_chk u_rc4_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .req_op_i       (req_i.op),
  .req_last_i     (req_i.last),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_out_byte_i (rsp_o.out_byte),
  .rsp_status_i   (rsp_o.status)
);
